// ===== rtl/bffra_pkg.sv =====
// Package for the bitmap first-fit run allocator.
// Holds the payload widths and the sequencer state type; no dependencies.
`default_nettype none

package bffra_pkg;

    // Payload widths of the request and result items.
    localparam int REQ_W   = 10;
    localparam int START_W = 9;
    localparam int GRANT_W = 10;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ADD,
        ST_DONE
    } alloc_state_t;

endpackage : bffra_pkg

`default_nettype wire

// ===== rtl/bitmap_first_fit_run_allocator.sv =====
// Top level of the bitmap first-fit run allocator.
// Depends on bffra_pkg for payload widths and the sequencer state type.
//
// Usage: a request item carries request_blocks, the number of contiguous
// blocks wanted, and the result item gives found, start_block and
// granted_blocks. Both channels use valid/ready; an item moves when valid and
// ready are both high at a rising edge of clk.
//
// Every grant starts at the first free block and claims blocks in order, and
// blocks are never freed, so the in-use blocks always form one run from block
// 0. The usage bitmap is therefore held as a fill count, and a request is
// served as min(request, NUM_BLOCKS - fill), starting at block fill.
//
// The arithmetic is bit serial, least significant bit first, over SER_W bits
// (the wider of the fill count and the request): one pass forms the free
// count and compares it with the request, a second adds the grant to the fill
// count. The result is registered from the done state, and in_ready rises
// with it, so a new item is taken only once the last one has its result. If
// the receiver stalls, the next item is still accepted and worked, then waits
// in its last state until the output register is free. Reset (rst_n low,
// asynchronous) marks every block free and drops out_valid.
`default_nettype none

module bitmap_first_fit_run_allocator
    import bffra_pkg::*;
#(
    parameter int NUM_BLOCKS = 512
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [REQ_W-1:0]     request_blocks,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      found,
    output logic [START_W-1:0]        start_block,
    output logic [GRANT_W-1:0]        granted_blocks
);

    // Width of the fill count, and of the serial datapath.
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int SER_W  = (CNT_W > REQ_W) ? CNT_W : REQ_W;
    localparam int BIT_W  = $clog2(SER_W);
    localparam logic [SER_W-1:0] TOTAL    = SER_W'(NUM_BLOCKS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(SER_W - 1);

    alloc_state_t           state_reg, state_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [SER_W-1:0]       want_reg, want_next;
    logic [SER_W-1:0]       free_reg, free_next;
    logic [SER_W-1:0]       used_reg, used_next;
    logic                   bor_free_reg, bor_free_next;
    logic                   bor_cmp_reg, bor_cmp_next;
    logic                   carry_reg, carry_next;
    logic [START_W-1:0]     start_reg, start_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [START_W-1:0]     start_out_reg, start_out_next;
    logic [GRANT_W-1:0]     grant_out_reg, grant_out_next;

    // Serial bit slices.
    logic                   u_bit, w_bit, n_bit, r_bit, f_bit, g_bit, s_bit;
    logic [SER_W-1:0]       grant_full;
    logic                   grant_nz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            used_reg      <= '0;
            bor_free_reg  <= 1'b0;
            bor_cmp_reg   <= 1'b0;
            carry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            used_reg      <= used_next;
            bor_free_reg  <= bor_free_next;
            bor_cmp_reg   <= bor_cmp_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        free_reg      <= free_next;
        start_reg     <= start_next;
        found_reg     <= found_next;
        start_out_reg <= start_out_next;
        grant_out_reg <= grant_out_next;
    end

    always_comb
    begin
        // Bits leaving the shift registers this cycle.
        u_bit = used_reg[0];
        w_bit = want_reg[0];
        n_bit = TOTAL[bit_reg];
        f_bit = free_reg[0];

        // Free blocks: TOTAL - used, one bit per cycle.
        r_bit = n_bit ^ u_bit ^ bor_free_reg;

        // Grant bit: the request when it is below the free count, else the
        // free count.
        g_bit = bor_cmp_reg ? w_bit : f_bit;
        s_bit = u_bit ^ g_bit ^ carry_reg;

        grant_full = bor_cmp_reg ? want_reg : free_reg;
        grant_nz   = |grant_full[GRANT_W-1:0];

        state_next     = state_reg;
        bit_next       = bit_reg;
        want_next      = want_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        bor_free_next  = bor_free_reg;
        bor_cmp_next   = bor_cmp_reg;
        carry_next     = carry_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        start_out_next = start_out_reg;
        grant_out_next = grant_out_reg;

        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                bit_next = '0;
                if (in_valid)
                begin
                    want_next     = SER_W'(request_blocks);
                    bor_free_next = 1'b0;
                    bor_cmp_next  = 1'b0;
                    state_next    = ST_CMP;
                end
            end

            ST_CMP:
            begin
                // Form the free count and subtract it from the request; a
                // final borrow means the request is smaller.
                free_next     = {r_bit, free_reg[SER_W-1:1]};
                want_next     = {w_bit, want_reg[SER_W-1:1]};
                used_next     = {u_bit, used_reg[SER_W-1:1]};
                bor_free_next = (!n_bit && u_bit) || (!(n_bit ^ u_bit) && bor_free_reg);
                bor_cmp_next  = (!w_bit && r_bit) || (!(w_bit ^ r_bit) && bor_cmp_reg);
                if (bit_reg == BIT_LAST)
                begin
                    bit_next   = '0;
                    carry_next = 1'b0;
                    state_next = ST_ADD;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end

            ST_ADD:
            begin
                // The fill count is aligned on the first cycle: it is the
                // first free block.
                if (bit_reg == '0)
                begin
                    start_next = used_reg[START_W-1:0];
                end
                free_next  = {f_bit, free_reg[SER_W-1:1]};
                want_next  = {w_bit, want_reg[SER_W-1:1]};
                used_next  = {s_bit, used_reg[SER_W-1:1]};
                carry_next = (u_bit && g_bit) || (carry_reg && (u_bit ^ g_bit));
                if (bit_reg == BIT_LAST)
                begin
                    bit_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                // Wait here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = grant_nz;
                    start_out_next = grant_nz ? start_reg : '0;
                    grant_out_next = grant_full[GRANT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign start_block    = start_out_reg;
    assign granted_blocks = grant_out_reg;

endmodule : bitmap_first_fit_run_allocator

`default_nettype wire
